// ===== sv/rrf_pkg.sv =====
// Package for the rounded rectangle alpha fill engine.
// Holds screen limits, field widths, register codes and the geometry struct.
// No dependencies; every other file of the block imports it.
package rrf_pkg;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 768;

   localparam int COORD_W = 12;
   localparam int PIXEL_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Screen limits in 13 bits so a 4096 limit still fits.
   localparam logic [12:0] SCR_W_LIM = 13'(SCREEN_WIDTH);
   localparam logic [12:0] SCR_H_LIM = 13'(SCREEN_HEIGHT);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RECT_LEFT     = 3'd0,
      REG_RECT_TOP      = 3'd1,
      REG_RECT_WIDTH    = 3'd2,
      REG_RECT_HEIGHT   = 3'd3,
      REG_CORNER_RADIUS = 3'd4,
      REG_FILL_COLOR    = 3'd5,
      REG_FILL_ALPHA    = 3'd6
   } csr_idx_type;

   typedef logic signed [15:0] edge_type;

   // Precomputed rectangle edges in screen coordinates.
   typedef struct packed {
      edge_type x_lo;     // left
      edge_type x_hi;     // left + width
      edge_type xb_lo;    // left + r
      edge_type xb_hi;    // left + width - r
      edge_type cx_far;   // left + width - r - 1
      edge_type y_lo;
      edge_type y_hi;
      edge_type yb_lo;
      edge_type yb_hi;
      edge_type cy_far;
   } geom_type;

endpackage

// ===== sv/rrf_req_if.sv =====
// Request channel interface of the fill engine: one pixel and its coordinates.
// Depends on rrf_pkg for the field widths.
interface rrf_req_if import rrf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pix_x;
   logic [COORD_W-1:0] pix_y;
   logic [PIXEL_W-1:0] dst_pixel;

   modport source (output valid, pix_x, pix_y, dst_pixel, input ready);
   modport sink   (input valid, pix_x, pix_y, dst_pixel, output ready);
endinterface

// ===== sv/rrf_rsp_if.sv =====
// Response channel interface of the fill engine: the pixel to write back.
// Depends on rrf_pkg for the field widths.
interface rrf_rsp_if import rrf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_pixel;
   logic               covered;

   modport source (output valid, out_pixel, covered, input ready);
   modport sink   (input valid, out_pixel, covered, output ready);
endinterface

// ===== sv/rounded_rect_alpha_fill_top.sv =====
// Rounded rectangle alpha fill engine, top level.
// Holds the handshake, the stage valid bits and the pixel pipeline.
// Depends on rrf_pkg, rrf_req_if, rrf_rsp_if, rrf_cfg, rrf_cover and rrf_blend.
//
// Usage: one pixel is transferred on req_ch per cycle with its screen
// coordinates and current framebuffer color. Exactly one result is
// transferred on rsp_ch for every request, in order: the blended color with
// covered set when the pixel lies inside the rounded rectangle and the
// screen, else the original color with covered clear.
// Throughput is one pixel per clock while rsp_ch does not stall; the four
// stages are the input register, the edge compare stage, the multiplier
// stage and the distance compare and divide stage, all advancing together.
// A response is valid while its pixel sits in the last of these stages.
// When rsp_ch stalls, the whole pipeline holds and req_ch.ready drops in the
// same cycle; nothing is dropped or repeated.
// Registers are written on the csr_ port; the derived edges are registered
// from the written registers and the squared radius from a further register
// of the clamped radius, which a pixel transferred on the next edge still
// sees when it reaches those stages. Reset is synchronous: all stages empty,
// registers take their defaults (radius 1, alpha 255, everything else zero),
// and no request is taken while reset is high.
module rounded_rect_alpha_fill_top import rrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rrf_req_if.sink               req_ch,
   rrf_rsp_if.source             rsp_ch
);

   geom_type           geom;
   logic [23:0]        radius_sq;
   logic [PIXEL_W-1:0] fill_color;
   logic [7:0]         fill_alpha;

   // Every stage moves when the output register is empty or being taken.
   logic adv;

   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff;
   logic [COORD_W-1:0] px_a_ff, py_a_ff;
   logic [PIXEL_W-1:0] dst_a_ff, dst_b_ff, dst_c_ff, dst_d_ff;
   logic [PIXEL_W-1:0] blended;
   logic               cov_d;

   assign adv          = !v_d_ff || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;

   rrf_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .geom       (geom),
      .radius_sq  (radius_sq),
      .fill_color (fill_color),
      .fill_alpha (fill_alpha)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
      end else if (adv) begin
         v_a_ff <= req_ch.valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         v_d_ff <= v_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_a_ff  <= req_ch.pix_x;
         py_a_ff  <= req_ch.pix_y;
         dst_a_ff <= req_ch.dst_pixel;
         dst_b_ff <= dst_a_ff;
         dst_c_ff <= dst_b_ff;
         dst_d_ff <= dst_c_ff;
      end
   end

   // Coverage test: stages B, C and D.
   rrf_cover u_cover (
      .clock     (clock),
      .adv       (adv),
      .pix_x     (px_a_ff),
      .pix_y     (py_a_ff),
      .geom      (geom),
      .radius_sq (radius_sq),
      .covered   (cov_d)
   );

   // Blend: products into stage C, quotient into stage D.
   rrf_blend u_blend (
      .clock   (clock),
      .adv     (adv),
      .dst     (dst_b_ff),
      .src     (fill_color),
      .alpha   (fill_alpha),
      .blended (blended)
   );

   // Stage D drives the response; uncovered pixels pass through untouched.
   assign rsp_ch.valid     = v_d_ff;
   assign rsp_ch.covered   = cov_d;
   assign rsp_ch.out_pixel = cov_d ? blended : dst_d_ff;

`ifndef ASSERT_OFF
   // A stall freezes every stage's occupancy.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({v_a_ff, v_b_ff, v_c_ff, v_d_ff}))
      else $error("pipeline occupancy changed during a stall");

   // A request transfer always lands in the first stage.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_a_ff)
      else $error("accepted pixel missing from the first stage");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule

// ===== sv/rrf_cfg.sv =====
// Configuration registers of the fill engine and the derived rectangle edges.
// Depends on rrf_pkg.
module rrf_cfg import rrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output geom_type              geom,
   output logic [23:0]           radius_sq,
   output logic [PIXEL_W-1:0]    fill_color,
   output logic [7:0]            fill_alpha
);

   logic [12:0] left_ff, left_in;
   logic [12:0] top_ff, top_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [11:0] radius_ff, radius_in;
   logic [23:0] color_ff, color_in;
   logic [7:0]  alpha_ff, alpha_in;

   logic [11:0] r0, r1, r2;
   logic [11:0] reff_ff;
   logic [23:0] rr_ff, rr_in;
   geom_type    geom_ff, geom_in;
   edge_type    xs, ys, ws, hs, rs;

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      color_in  = color_ff;
      alpha_in  = alpha_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            REG_RECT_LEFT:     left_in   = csr_wdata[12:0];
            REG_RECT_TOP:      top_in    = csr_wdata[12:0];
            REG_RECT_WIDTH:    width_in  = csr_wdata[12:0];
            REG_RECT_HEIGHT:   height_in = csr_wdata[12:0];
            REG_CORNER_RADIUS: radius_in = csr_wdata[11:0];
            REG_FILL_COLOR:    color_in  = csr_wdata[23:0];
            REG_FILL_ALPHA:    alpha_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= 12'd1;
         color_ff  <= '0;
         alpha_ff  <= 8'd255;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
         color_ff  <= color_in;
         alpha_ff  <= alpha_in;
      end
   end

   // Radius: at least one, then no more than half the width and half the height.
   always_comb begin
      r0 = (radius_ff == 12'd0) ? 12'd1 : radius_ff;
      r1 = ({r0, 1'b0} > width_ff) ? width_ff[12:1] : r0;
      r2 = ({r1, 1'b0} > height_ff) ? height_ff[12:1] : r1;

      xs = edge_type'($signed({{3{left_ff[12]}}, left_ff}));
      ys = edge_type'($signed({{3{top_ff[12]}}, top_ff}));
      ws = edge_type'({3'b000, width_ff});
      hs = edge_type'({3'b000, height_ff});
      rs = edge_type'({4'b0000, r2});

      geom_in.x_lo   = xs;
      geom_in.x_hi   = xs + ws;
      geom_in.xb_lo  = xs + rs;
      geom_in.xb_hi  = xs + ws - rs;
      geom_in.cx_far = xs + ws - rs - 16'sd1;
      geom_in.y_lo   = ys;
      geom_in.y_hi   = ys + hs;
      geom_in.yb_lo  = ys + rs;
      geom_in.yb_hi  = ys + hs - rs;
      geom_in.cy_far = ys + hs - rs - 16'sd1;

      rr_in = 24'(reff_ff) * 24'(reff_ff);
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
      reff_ff <= r2;
      rr_ff   <= rr_in;
   end

   assign geom       = geom_ff;
   assign radius_sq  = rr_ff;
   assign fill_color = color_ff;
   assign fill_alpha = alpha_ff;

endmodule

// ===== sv/rrf_cover.sv =====
// Coverage pipeline of the fill engine: edge compares, corner squares, distance test.
// Depends on rrf_pkg; three register stages that advance on the shared enable.
module rrf_cover import rrf_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [COORD_W-1:0] pix_x,
   input  logic [COORD_W-1:0] pix_y,
   input  geom_type           geom,
   input  logic [23:0]        radius_sq,
   output logic               covered
);

   edge_type    pxs, pys, cx, cy, dx, dy, adx, ady;
   logic        onscr, inbox_in, band_in;

   logic        inbox_b_ff, band_b_ff;
   logic [11:0] adx_b_ff, ady_b_ff;
   logic        inbox_c_ff, band_c_ff;
   logic [23:0] dx2_c_ff, dy2_c_ff, dx2_in, dy2_in;
   logic        cov_d_ff, cov_in;
   logic [24:0] dist_sum;

   // Stage B: box, band and corner offsets.
   always_comb begin
      pxs = edge_type'({4'b0000, pix_x});
      pys = edge_type'({4'b0000, pix_y});
      onscr = ({1'b0, pix_x} < SCR_W_LIM) && ({1'b0, pix_y} < SCR_H_LIM);
      inbox_in = onscr && (pxs >= geom.x_lo) && (pxs < geom.x_hi) &&
                 (pys >= geom.y_lo) && (pys < geom.y_hi);
      band_in = ((pxs >= geom.xb_lo) && (pxs < geom.xb_hi)) ||
                ((pys >= geom.yb_lo) && (pys < geom.yb_hi));
      cx  = (pxs < geom.xb_lo) ? geom.xb_lo : geom.cx_far;
      cy  = (pys < geom.yb_lo) ? geom.yb_lo : geom.cy_far;
      dx  = pxs - cx;
      dy  = pys - cy;
      adx = dx[15] ? -dx : dx;
      ady = dy[15] ? -dy : dy;
   end

   // Stage C: squares. Within a corner the offsets never exceed the radius.
   always_comb begin
      dx2_in = 24'(adx_b_ff) * 24'(adx_b_ff);
      dy2_in = 24'(ady_b_ff) * 24'(ady_b_ff);
   end

   // Stage D: distance against radius squared.
   always_comb begin
      dist_sum = {1'b0, dx2_c_ff} + {1'b0, dy2_c_ff};
      cov_in   = inbox_c_ff && (band_c_ff || (dist_sum <= {1'b0, radius_sq}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         inbox_b_ff <= inbox_in;
         band_b_ff  <= band_in;
         adx_b_ff   <= adx[11:0];
         ady_b_ff   <= ady[11:0];
         inbox_c_ff <= inbox_b_ff;
         band_c_ff  <= band_b_ff;
         dx2_c_ff   <= dx2_in;
         dy2_c_ff   <= dy2_in;
         cov_d_ff   <= cov_in;
      end
   end

   assign covered = cov_d_ff;

endmodule

// ===== sv/rrf_blend.sv =====
// Color path of the fill engine: per channel multiply-add, then divide by 255.
// Depends on rrf_pkg; two register stages that advance on the shared enable.
module rrf_blend import rrf_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [PIXEL_W-1:0] dst,
   input  logic [PIXEL_W-1:0] src,
   input  logic [7:0]         alpha,
   output logic [PIXEL_W-1:0] blended
);

   logic [15:0] sum_in [3];
   logic [15:0] sum_ff [3];
   logic [16:0] rnd    [3];
   logic [7:0]  q_in   [3];
   logic [PIXEL_W-1:0] q_ff;
   logic [7:0]  inv_a;

   always_comb begin
      inv_a = 8'd255 - alpha;
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = 16'(src[8*c +: 8]) * 16'(alpha) +
                     16'(dst[8*c +: 8]) * 16'(inv_a);
         // Exact floor(v / 255) for any v up to 255 * 255.
         rnd[c]  = 17'(sum_ff[c]) + 17'd1 + 17'(sum_ff[c][15:8]);
         q_in[c] = rnd[c][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]      <= sum_in[c];
            q_ff[8*c +: 8] <= q_in[c];
         end
      end
   end

   assign blended = q_ff;

endmodule

// ===== dv/rrf_fill_check_pkg.sv =====
// Pixel predictor and result checker for the rounded rectangle alpha fill engine.
// Depends on rrf_pkg for the register codes, the field widths and the screen size.
package rrf_fill_check_pkg;
   import rrf_pkg::*;

   localparam int unsigned FULL_ALPHA = 255;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_pixel;
      logic               covered;
   } fill_result_type;

   class fill_checker;
      logic signed [12:0] left;
      logic signed [12:0] top;
      logic [12:0]        width;
      logic [12:0]        height;
      logic [11:0]        radius;
      logic [23:0]        color;
      logic [7:0]         alpha;
      fill_result_type    pending_pixels[$];
      int                 errors;

      function new();
         left   = '0;
         top    = '0;
         width  = '0;
         height = '0;
         radius = 12'd1;
         color  = '0;
         alpha  = 8'd255;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_RECT_LEFT:     left   = data[12:0];
            REG_RECT_TOP:      top    = data[12:0];
            REG_RECT_WIDTH:    width  = data[12:0];
            REG_RECT_HEIGHT:   height = data[12:0];
            REG_CORNER_RADIUS: radius = data[11:0];
            REG_FILL_COLOR:    color  = data[23:0];
            REG_FILL_ALPHA:    alpha  = data[7:0];
            default: ;
         endcase
      endfunction

      function bit in_rounded_rect(int px, int py);
         int     x0, y0, w, h, r, cx, cy;
         longint dx, dy;
         x0 = left;
         y0 = top;
         w  = width;
         h  = height;
         r  = radius;
         // The radius is at least one, then limited to half of each side.
         if (r < 1) r = 1;
         if (r * 2 > w) r = w / 2;
         if (r * 2 > h) r = h / 2;
         if (px < x0 || py < y0 || px >= x0 + w || py >= y0 + h) return 1'b0;
         if (px >= x0 + r && px < x0 + w - r) return 1'b1;
         if (py >= y0 + r && py < y0 + h - r) return 1'b1;
         cx = (px < x0 + r) ? x0 + r : x0 + w - r - 1;
         cy = (py < y0 + r) ? y0 + r : y0 + h - r - 1;
         dx = px - cx;
         dy = py - cy;
         return (dx * dx + dy * dy) <= longint'(r) * r;
      endfunction

      function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
         int unsigned num;
         num = s * a + d * (FULL_ALPHA - a);
         return 8'(num / FULL_ALPHA);
      endfunction

      function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [PIXEL_W-1:0] dst);
         fill_result_type res;
         res.covered = (x < SCREEN_WIDTH) && (y < SCREEN_HEIGHT) && in_rounded_rect(x, y);
         if (res.covered)
            res.out_pixel = {mix_channel(color[23:16], dst[23:16], alpha),
                             mix_channel(color[15:8], dst[15:8], alpha),
                             mix_channel(color[7:0], dst[7:0], alpha)};
         else
            res.out_pixel = dst;
         pending_pixels.push_back(res);
      endfunction

      function void check_pixel(logic [PIXEL_W-1:0] out_pixel, logic covered);
         fill_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("result transfer with no pixel outstanding: out_pixel %06h", out_pixel);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         if (out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %06h, actual %06h", want.out_pixel, out_pixel);
            errors++;
         end
         if (covered !== want.covered) begin
            $error("covered: expected %0b, actual %0b", want.covered, covered);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== dv/rounded_rect_alpha_fill_top_test.sv =====
// Self-checking test of rounded_rect_alpha_fill_top: directed pixels, then random phases.
// Depends on rrf_pkg, the two channel interfaces, the block and rrf_fill_check_pkg.
module rounded_rect_alpha_fill_top_test;
   import rrf_pkg::*;
   import rrf_fill_check_pkg::*;

   localparam int PIPE_LATENCY  = 4;
   localparam int PHASE_PIXELS  = 123;
   localparam int PHASE_COUNT   = 10;
   localparam int LONG_HOLD     = 200;
   localparam int LIMIT_CYCLES  = 400000;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rrf_req_if req_ch ();
   rrf_rsp_if rsp_ch ();

   rounded_rect_alpha_fill_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   fill_checker fill_sb;

   // Percent of cycles in which the sender leaves a gap or the receiver stalls.
   int send_idle_pct;
   int recv_stall_pct;
   // Cycles left in a forced receiver hold-off; counted down by the receiver.
   int hold_left;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Safety net: the slowest legal run is far shorter than this.
   initial begin
      #(LIMIT_CYCLES * 8);
      $display("== FAIL ==");
      $finish;
   end

   // Receiver. The ready decision is made at the rising edge and holds for the
   // whole cycle, so a transfer is seen unambiguously at the falling edge,
   // when all outputs of the block have settled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every response transfer is checked against the oldest predicted pixel.
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         fill_sb.check_pixel(rsp_ch.out_pixel, rsp_ch.covered);
   end

   // Offers one pixel, optionally after a random gap, and returns in the time
   // step of the rising edge at which the transfer took place. Ready is looked
   // at on the falling edge before, so the decision never races the block.
   task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PIXEL_W-1:0] dst);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.pix_x     <= x;
      req_ch.pix_y     <= y;
      req_ch.dst_pixel <= dst;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end
      fill_sb.note_pixel(x, y, dst);
   endtask

   // Stops offering pixels, waits for every outstanding result, and then lets
   // the pipeline run dry before anything else happens.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (fill_sb.pending_pixels.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      fill_sb.write_reg(idx, data);
   endtask

   // Programs a complete rectangle. The unused index is written last with
   // random data, so any aliasing onto a real register would show up.
   task automatic program_rect(int l, int t, int w, int h, int r,
                               logic [23:0] color, logic [7:0] alpha);
      wait_idle();
      csr_write(REG_RECT_LEFT, CSR_DATA_W'(l));
      csr_write(REG_RECT_TOP, CSR_DATA_W'(t));
      csr_write(REG_RECT_WIDTH, CSR_DATA_W'(w));
      csr_write(REG_RECT_HEIGHT, CSR_DATA_W'(h));
      csr_write(REG_CORNER_RADIUS, CSR_DATA_W'(r));
      csr_write(REG_FILL_COLOR, color);
      csr_write(REG_FILL_ALPHA, CSR_DATA_W'(alpha));
      csr_write(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // A random setting: mostly small rectangles on screen so that corners and
   // bands are hit often, or one built from extreme register values.
   task automatic program_random_rect(bit extreme);
      int l, t, w, h, r;
      logic [7:0] a;
      if (extreme) begin
         case ($urandom_range(5))
            0: l = -4096;
            1: l = 4095;
            2: l = -2048;
            3: l = -1;
            4: l = 1000;
            default: l = 0;
         endcase
         case ($urandom_range(4))
            0: t = -4096;
            1: t = 4095;
            2: t = -2048;
            3: t = 740;
            default: t = 0;
         endcase
         case ($urandom_range(4))
            0: w = 0;
            1: w = 1;
            2: w = 2;
            3: w = 4096;
            default: w = $urandom_range(4096);
         endcase
         case ($urandom_range(4))
            0: h = 0;
            1: h = 1;
            2: h = 3;
            3: h = 4096;
            default: h = $urandom_range(4096);
         endcase
         case ($urandom_range(3))
            0: r = 0;
            1: r = 2048;
            2: r = 1;
            default: r = $urandom_range(2048);
         endcase
         case ($urandom_range(3))
            0: a = 8'd0;
            1: a = 8'd255;
            2: a = 8'd1;
            default: a = 8'd254;
         endcase
      end else begin
         w = $urandom_range(80);
         h = $urandom_range(80);
         l = $urandom_range(1100) - 40;
         t = $urandom_range(840) - 40;
         r = $urandom_range(45);
         a = $urandom_range(255);
      end
      program_rect(l, t, w, h, r, 24'($urandom), a);
   endtask

   // Pixels are drawn mostly around the rectangle, then across the screen and
   // just past its far edges, and the rest across the whole coordinate range.
   task automatic send_random_pixel();
      int sel, px, py;
      sel = $urandom_range(99);
      if (sel < 60) begin
         px = int'(fill_sb.left) - 2 + int'($urandom_range(int'(fill_sb.width) + 3));
         py = int'(fill_sb.top) - 2 + int'($urandom_range(int'(fill_sb.height) + 3));
      end else if (sel < 85) begin
         px = $urandom_range(SCREEN_WIDTH + 1);
         py = $urandom_range(SCREEN_HEIGHT + 1);
      end else begin
         px = $urandom_range(4095);
         py = $urandom_range(4095);
      end
      if (px < 0 || px > 4095) px = $urandom_range(4095);
      if (py < 0 || py > 4095) py = $urandom_range(4095);
      send_pixel(COORD_W'(px), COORD_W'(py), PIXEL_W'($urandom));
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct  = 85;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 85;
         end
         IDLE_BOTH: begin
            send_idle_pct  = 24;
            recv_stall_pct = 24;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   initial begin
      fill_sb          = new();
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_left        = 0;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= REG_RECT_LEFT;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.pix_x     <= '0;
      req_ch.pix_y     <= '0;
      req_ch.dst_pixel <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values give a zero-size rectangle, which covers nothing.
      send_pixel(12'd0, 12'd0, 24'hFFFFFF);
      send_pixel(12'd5, 12'd5, 24'h000000);

      // A plain rounded rectangle at half opacity. The pixels probe the
      // outer tip of each near and far corner, points just inside the arc,
      // both straight bands and one pixel past each edge.
      program_rect(10, 20, 40, 30, 8, 24'h123456, 8'd128);
      send_pixel(12'd10, 12'd20, 24'hFFFFFF);
      send_pixel(12'd18, 12'd20, 24'h000000);
      send_pixel(12'd12, 12'd22, 24'hABCDEF);
      send_pixel(12'd13, 12'd23, 24'hFFFFFF);
      send_pixel(12'd30, 12'd20, 24'h808080);
      send_pixel(12'd10, 12'd35, 24'h0F0F0F);
      send_pixel(12'd49, 12'd49, 24'h000000);
      send_pixel(12'd41, 12'd49, 24'hFFFFFF);
      send_pixel(12'd50, 12'd35, 24'h55AA55);
      send_pixel(12'd9, 12'd35, 24'hAA55AA);
      send_pixel(12'd30, 12'd50, 24'h123123);
      send_pixel(12'd30, 12'd19, 24'h321321);

      // A huge rectangle with the largest radius, fully transparent fill:
      // covered pixels keep their color, off-screen ones are not covered.
      program_rect(-2048, -2048, 4096, 4096, 2048, 24'hFFFFFF, 8'd0);
      send_pixel(12'd1023, 12'd767, 24'h13579B);
      send_pixel(12'd1024, 12'd0, 24'hFFFFFF);
      send_pixel(12'd0, 12'd768, 24'h000000);
      send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);

      // A one-pixel rectangle: the radius collapses to zero and only the
      // pixel itself is covered, opaque.
      program_rect(100, 100, 1, 1, 0, 24'hA5A5A5, 8'd255);
      send_pixel(12'd100, 12'd100, 24'h5A5A5A);
      send_pixel(12'd101, 12'd100, 24'h5A5A5A);
      send_pixel(12'd100, 12'd99, 24'h000000);

      // A rectangle whose corner lies at the very end of the coordinate range.
      program_rect(4095, 4095, 4096, 4096, 2048, 24'h00FF00, 8'd1);
      send_pixel(12'd4095, 12'd4095, 24'h0000FF);
      send_pixel(12'd1023, 12'd0, 24'hFF0000);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         program_random_rect(phase % 3 == 2);
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 4) begin
            // The receiver holds off while the sender keeps offering pixels,
            // so the pipeline fills and the block has to stall its input.
            @(negedge clock);
            hold_left = LONG_HOLD;
            @(posedge clock);
         end
         for (int n = 0; n < PHASE_PIXELS; n++)
            send_random_pixel();
      end

      wait_idle();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (fill_sb.errors == 0 && fill_sb.pending_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
